[rtl/tbdc_pkg.sv]
package tbdc_pkg;

  localparam int FACTOR_W = 9;
  localparam int WLIM_W   = 10;
  localparam int HOLD_W   = 10;
  localparam int CNT_W    = 16;
  localparam int STAT_W   = 4;

  localparam logic [STAT_W-1:0] ST_NONE       = 4'd0;
  localparam logic [STAT_W-1:0] ST_UP         = 4'd1;
  localparam logic [STAT_W-1:0] ST_DOWN       = 4'd2;
  localparam logic [STAT_W-1:0] ST_WAIT       = 4'd3;
  localparam logic [STAT_W-1:0] ST_TIMEOUT    = 4'd4;
  localparam logic [STAT_W-1:0] ST_SENSOR_ERR = 4'd5;
  localparam logic [STAT_W-1:0] ST_CAL        = 4'd6;
  localparam logic [STAT_W-1:0] ST_CAL_DONE   = 4'd7;
  localparam logic [STAT_W-1:0] ST_CAL_FAIL   = 4'd8;
  localparam logic [STAT_W-1:0] ST_HOLD       = 4'd9;

  localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;
  localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

  // register index, byte address is four times this
  typedef enum logic [1:0] {
    REG_FACTOR     = 2'd0,
    REG_WAIT_LIMIT = 2'd1,
    REG_HOLDOFF    = 2'd2
  } cfg_reg_t;

  // per-beat commands from the control stage to both sensor lanes
  typedef struct packed {
    logic clear;
    logic add;
    logic load;
  } lane_ctl_t;

  // result beat, status in the low bits
  typedef struct packed {
    logic signed [CNT_W-1:0] prev;
    logic signed [CNT_W-1:0] occ;
    logic [STAT_W-1:0]       status;
  } result_t;

endpackage

[rtl/tbdc_lane.sv]
module tbdc_lane #(
  parameter int ECHO_BITS   = 16,
  parameter int CAL_SAMPLES = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  input  tbdc_pkg::lane_ctl_t             ctl,
  input  logic [ECHO_BITS-1:0]            echo,
  input  logic [tbdc_pkg::FACTOR_W-1:0]   factor,
  output logic                            present
);
  import tbdc_pkg::*;

  localparam int SUM_W = ECHO_BITS + $clog2(CAL_SAMPLES + 1);
  localparam int LIM_W = SUM_W + FACTOR_W;

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [LIM_W-1:0] limit_r, limit_nxt;
  logic [SUM_W-1:0] sum_add;
  logic [SUM_W-1:0] echo_mul;

  assign sum_add  = sum_r + SUM_W'(echo);
  assign echo_mul = SUM_W'(echo) * SUM_W'(CAL_SAMPLES);

  // echo * samples * 256 against sum * factor, both exact
  assign present = {1'b0, echo_mul, 8'd0} < limit_r;

  always_comb begin
    sum_nxt   = sum_r;
    limit_nxt = limit_r;
    if (ctl.clear) begin
      sum_nxt = '0;
    end else if (ctl.add) begin
      sum_nxt = sum_add;
    end else if (ctl.load) begin
      sum_nxt   = sum_add;
      limit_nxt = LIM_W'(sum_add) * LIM_W'(factor);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      limit_r <= '0;
    end else if (fire) begin
      sum_r   <= sum_nxt;
      limit_r <= limit_nxt;
    end
  end

endmodule

[rtl/tbdc_ctrl.sv]
module tbdc_ctrl #(
  parameter int CAL_SAMPLES = 10,
  parameter int WAIT_BITS   = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic                          op,
  input  logic                          ok_a,
  input  logic                          ok_b,
  input  logic                          pres_a,
  input  logic                          pres_b,
  input  logic [tbdc_pkg::WLIM_W-1:0]   wait_limit,
  input  logic [tbdc_pkg::HOLD_W-1:0]   holdoff_samples,
  output tbdc_pkg::lane_ctl_t           ctl,
  output tbdc_pkg::result_t             res
);
  import tbdc_pkg::*;

  localparam int IDX_W  = $clog2(CAL_SAMPLES + 1);
  localparam int WCMP_W = (WAIT_BITS > WLIM_W) ? WAIT_BITS : WLIM_W;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_WAIT_B = 2'd1;
  localparam logic [1:0] MODE_WAIT_A = 2'd2;
  localparam logic [1:0] MODE_HOLD   = 2'd3;

  logic [1:0]              mode_r, mode_nxt;
  logic [WAIT_BITS-1:0]    wait_r, wait_nxt;
  logic [HOLD_W-1:0]       hold_r, hold_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    cal_r, cal_nxt;
  logic signed [CNT_W-1:0] cnt_r, cnt_nxt;
  logic signed [CNT_W-1:0] prior_r, prior_nxt;
  logic [STAT_W-1:0]       status;
  logic                    sel_ok, sel_seen, dir_up;
  logic [WAIT_BITS-1:0]    wait_inc;
  logic [WCMP_W-1:0]       wait_lim_m;

  assign sel_ok     = (mode_r == MODE_WAIT_B) ? ok_b : ok_a;
  assign sel_seen   = (mode_r == MODE_WAIT_B) ? pres_b : pres_a;
  assign dir_up     = (mode_r == MODE_WAIT_A);
  assign wait_inc   = wait_r + 1'b1;
  assign wait_lim_m = WCMP_W'(wait_limit) & WCMP_W'((1 << WAIT_BITS) - 1);

  always_comb begin
    mode_nxt  = mode_r;
    wait_nxt  = wait_r;
    hold_nxt  = hold_r;
    idx_nxt   = idx_r;
    cal_nxt   = cal_r;
    cnt_nxt   = cnt_r;
    prior_nxt = prior_r;
    ctl       = '0;
    status    = ST_NONE;
    if (op) begin
      cnt_nxt   = '0;
      prior_nxt = '0;
      idx_nxt   = '0;
      cal_nxt   = 1'b1;
      mode_nxt  = MODE_IDLE;
      wait_nxt  = '0;
      hold_nxt  = '0;
      ctl.clear = 1'b1;
      status    = ST_CAL;
    end else if (cal_r) begin
      if (!ok_a || !ok_b) begin
        cal_nxt = 1'b0;
        status  = ST_CAL_FAIL;
      end else if (idx_r == IDX_W'(CAL_SAMPLES - 1)) begin
        idx_nxt  = idx_r + 1'b1;
        cal_nxt  = 1'b0;
        ctl.load = 1'b1;
        status   = ST_CAL_DONE;
      end else begin
        idx_nxt = idx_r + 1'b1;
        ctl.add = 1'b1;
        status  = ST_CAL;
      end
    end else begin
      unique case (mode_r)
        MODE_HOLD: begin
          hold_nxt = (hold_r != '0) ? hold_r - 1'b1 : hold_r;
          if (hold_nxt == '0) begin
            mode_nxt = MODE_IDLE;
          end
          status = ST_HOLD;
        end
        MODE_WAIT_A, MODE_WAIT_B: begin
          if (!sel_ok) begin
            mode_nxt = MODE_IDLE;
            status   = ST_SENSOR_ERR;
          end else if (sel_seen) begin
            prior_nxt = cnt_r;
            if (dir_up && cnt_r != CNT_MAX) begin
              cnt_nxt = cnt_r + 16'sd1;
            end else if (!dir_up && cnt_r != CNT_MIN) begin
              cnt_nxt = cnt_r - 16'sd1;
            end
            if (holdoff_samples != '0) begin
              hold_nxt = holdoff_samples;
              mode_nxt = MODE_HOLD;
            end else begin
              mode_nxt = MODE_IDLE;
            end
            status = dir_up ? ST_UP : ST_DOWN;
          end else begin
            wait_nxt = wait_inc;
            if (WCMP_W'(wait_inc) >= wait_lim_m) begin
              mode_nxt = MODE_IDLE;
              status   = ST_TIMEOUT;
            end else begin
              status = ST_WAIT;
            end
          end
        end
        MODE_IDLE: begin
          if (!ok_a || !ok_b) begin
            status = ST_SENSOR_ERR;
          end else if (pres_a) begin
            mode_nxt = MODE_WAIT_B;
            wait_nxt = '0;
            status   = ST_WAIT;
          end else if (pres_b) begin
            mode_nxt = MODE_WAIT_A;
            wait_nxt = '0;
            status   = ST_WAIT;
          end else begin
            prior_nxt = cnt_r;
            status    = ST_NONE;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase
    end
  end

  assign res.status = status;
  assign res.occ    = cnt_nxt;
  assign res.prev   = prior_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      wait_r  <= '0;
      hold_r  <= '0;
      idx_r   <= '0;
      cal_r   <= 1'b0;
      cnt_r   <= '0;
      prior_r <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      wait_r  <= wait_nxt;
      hold_r  <= hold_nxt;
      idx_r   <= idx_nxt;
      cal_r   <= cal_nxt;
      cnt_r   <= cnt_nxt;
      prior_r <= prior_nxt;
    end
  end

  // holdoff is only entered with a nonzero count and left when it hits zero or on a start command
  a_hold_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_HOLD |-> hold_r != '0)
    else $error("holdoff mode with zero counter");

  a_cal_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cal_r |-> mode_r == MODE_IDLE)
    else $error("calibration running outside idle mode");

  a_cal_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cal_r |-> idx_r < IDX_W'(CAL_SAMPLES))
    else $error("calibration index past sample count");

  a_cal_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op |=> cnt_r == '0 && prior_r == '0 && cal_r)
    else $error("start of calibration did not clear the count");

endmodule

[rtl/two_beam_direction_counter_core.sv]
// Two-beam direction counter. Each input beat carries one echo width and valid flag per
// sensor, or a start-calibration command (in_tuser). One result beat comes out per input beat,
// in the cycle after acceptance at the earliest, and a new beat is accepted every cycle while
// the skid entry is empty: the two sensor lanes compare against their limits and the control
// stage updates mode and count within that cycle, so the mode/count state loop sets the
// one-beat-per-cycle rate. A two-entry output buffer keeps in_tready high while one result
// waits on out_tready. Calibration sums the next CAL_SAMPLES valid pairs; an invalid pair
// aborts it. The limits are loaded with the threshold factor in force on the last calibration
// beat. Registers: threshold_factor at 0x0, wait_limit at 0x4, holdoff_samples at 0x8.
module two_beam_direction_counter_core #(
  parameter int CAL_SAMPLES = 10,
  parameter int ECHO_BITS   = 16,
  parameter int WAIT_BITS   = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // echo_a_us, echo_a_ok, echo_b_us, echo_b_ok
  input  logic [((2*ECHO_BITS+2+7)/8)*8-1:0] in_tdata,
  // op
  input  logic [0:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // status, occupancy, previous_occupancy
  output logic [39:0]          out_tdata,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [3:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import tbdc_pkg::*;

  localparam int RES_W = $bits(result_t);

  logic [FACTOR_W-1:0] factor_r;
  logic [WLIM_W-1:0]   wait_lim_r;
  logic [HOLD_W-1:0]   holdoff_r;
  logic                cfg_wr;

  logic                 in_fire, out_fire;
  logic [ECHO_BITS-1:0] echo_a, echo_b;
  logic                 ok_a, ok_b, pres_a, pres_b;
  lane_ctl_t            ctl;
  result_t              res;

  logic    out_v_r, skid_v_r;
  result_t out_r, skid_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r   <= FACTOR_W'(204);
      wait_lim_r <= WLIM_W'(25);
      holdoff_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_FACTOR:     factor_r   <= cfg_pwdata[FACTOR_W-1:0];
        REG_WAIT_LIMIT: wait_lim_r <= cfg_pwdata[WLIM_W-1:0];
        REG_HOLDOFF:    holdoff_r  <= cfg_pwdata[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_FACTOR:     cfg_prdata = 32'(factor_r);
      REG_WAIT_LIMIT: cfg_prdata = 32'(wait_lim_r);
      REG_HOLDOFF:    cfg_prdata = 32'(holdoff_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // input beat unpacking
  assign echo_a = in_tdata[ECHO_BITS-1:0];
  assign ok_a   = in_tdata[ECHO_BITS];
  assign echo_b = in_tdata[2*ECHO_BITS:ECHO_BITS+1];
  assign ok_b   = in_tdata[2*ECHO_BITS+1];

  assign in_tready = !skid_v_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_v_r && out_tready;

  tbdc_lane #(
    .ECHO_BITS   (ECHO_BITS),
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_lane_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .ctl     (ctl),
    .echo    (echo_a),
    .factor  (factor_r),
    .present (pres_a)
  );

  tbdc_lane #(
    .ECHO_BITS   (ECHO_BITS),
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_lane_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .ctl     (ctl),
    .echo    (echo_b),
    .factor  (factor_r),
    .present (pres_b)
  );

  tbdc_ctrl #(
    .CAL_SAMPLES (CAL_SAMPLES),
    .WAIT_BITS   (WAIT_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (in_fire),
    .op              (in_tuser[0]),
    .ok_a            (ok_a),
    .ok_b            (ok_b),
    .pres_a          (pres_a),
    .pres_b          (pres_b),
    .wait_limit      (wait_lim_r),
    .holdoff_samples (holdoff_r),
    .ctl             (ctl),
    .res             (res)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_fire) begin
        skid_v_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_v_r && !out_fire) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_v_r && !out_fire) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(40 - RES_W)'(0), out_r};

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held with empty output register");

  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !in_tready)
    else $error("input accepted with both buffer entries full");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && out_fire |=> out_v_r && !skid_v_r)
    else $error("skid entry lost on output beat");

endmodule

[verif/two_beam_direction_counter_core_tb.sv]
`timescale 1ns / 1ps

import tbdc_pkg::*;

typedef enum logic [1:0] {
  TRK_IDLE,
  TRK_WAIT_B,
  TRK_WAIT_A,
  TRK_HOLD
} track_t;

localparam int CAL_LEN = 10;

class occupancy_checker;
  logic [FACTOR_W-1:0]     factor;
  logic [WLIM_W-1:0]       wait_lim;
  logic [HOLD_W-1:0]       hold_len;
  track_t                  track;
  logic [WLIM_W-1:0]       wait_cnt;
  logic [HOLD_W-1:0]       hold_cnt;
  int                      cal_idx;
  bit                      cal_on;
  longint unsigned         sum_a, sum_b, lim_a, lim_b;
  logic signed [CNT_W-1:0] count, prior;
  result_t                 pending_results[$];
  int                      errors, n_samples, n_live, n_results, hi_mark, lo_mark;

  function new();
    factor = 9'd204;
    wait_lim = 10'd25;
    hold_len = '0;
    track = TRK_IDLE;
    wait_cnt = '0;
    hold_cnt = '0;
    cal_idx = 0;
    cal_on = 1'b0;
    sum_a = 0;
    sum_b = 0;
    lim_a = 0;
    lim_b = 0;
    count = '0;
    prior = '0;
    errors = 0;
    n_samples = 0;
    n_live = 0;
    n_results = 0;
    hi_mark = 0;
    lo_mark = 0;
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 30) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function void set_reg(cfg_reg_t idx, logic [31:0] value);
    case (idx)
      REG_FACTOR:     factor = value[FACTOR_W-1:0];
      REG_WAIT_LIMIT: wait_lim = value[WLIM_W-1:0];
      REG_HOLDOFF:    hold_len = value[HOLD_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] reg_value(cfg_reg_t idx);
    case (idx)
      REG_FACTOR:     return 32'(factor);
      REG_WAIT_LIMIT: return 32'(wait_lim);
      default:        return 32'(hold_len);
    endcase
  endfunction

  // unscaled compare: echo * samples * 256 against sum * factor
  function bit beam_blocked(logic [15:0] echo, longint unsigned lim);
    return ({48'd0, echo} * 64'd2560) < lim;
  endfunction

  function void step_count(bit up);
    prior = count;
    if (up && count != CNT_MAX) count++;
    else if (!up && count != CNT_MIN) count--;
    if (hold_len != 0) begin
      hold_cnt = hold_len;
      track = TRK_HOLD;
    end else begin
      track = TRK_IDLE;
    end
  endfunction

  function logic [STAT_W-1:0] confirm_beam(bit ok, bit seen, bit up);
    if (!ok) begin
      track = TRK_IDLE;
      return ST_SENSOR_ERR;
    end
    if (seen) begin
      step_count(up);
      return up ? ST_UP : ST_DOWN;
    end
    wait_cnt = wait_cnt + 1'b1;
    if (wait_cnt >= wait_lim) begin
      track = TRK_IDLE;
      return ST_TIMEOUT;
    end
    return ST_WAIT;
  endfunction

  function void note_sample(bit op, logic [15:0] ea, bit oka, logic [15:0] eb, bit okb);
    logic [STAT_W-1:0] st;
    n_samples++;
    if (op || cal_on || track != TRK_HOLD) n_live++;
    if (op) begin
      count = '0;
      prior = '0;
      sum_a = 0;
      sum_b = 0;
      cal_idx = 0;
      cal_on = 1'b1;
      track = TRK_IDLE;
      wait_cnt = '0;
      hold_cnt = '0;
      st = ST_CAL;
    end else if (cal_on) begin
      if (!oka || !okb) begin
        cal_on = 1'b0;
        st = ST_CAL_FAIL;
      end else begin
        sum_a += ea;
        sum_b += eb;
        cal_idx++;
        if (cal_idx >= CAL_LEN) begin
          lim_a = sum_a * factor;
          lim_b = sum_b * factor;
          cal_on = 1'b0;
          st = ST_CAL_DONE;
        end else begin
          st = ST_CAL;
        end
      end
    end else if (track == TRK_HOLD) begin
      if (hold_cnt > 0) hold_cnt--;
      if (hold_cnt == 0) track = TRK_IDLE;
      st = ST_HOLD;
    end else if (track == TRK_WAIT_B) begin
      st = confirm_beam(okb, beam_blocked(eb, lim_b), 1'b0);
    end else if (track == TRK_WAIT_A) begin
      st = confirm_beam(oka, beam_blocked(ea, lim_a), 1'b1);
    end else if (!oka || !okb) begin
      st = ST_SENSOR_ERR;
    end else if (beam_blocked(ea, lim_a)) begin
      // A wins when both beams are blocked
      track = TRK_WAIT_B;
      wait_cnt = '0;
      st = ST_WAIT;
    end else if (beam_blocked(eb, lim_b)) begin
      track = TRK_WAIT_A;
      wait_cnt = '0;
      st = ST_WAIT;
    end else begin
      prior = count;
      st = ST_NONE;
    end
    if (int'(count) > hi_mark) hi_mark = int'(count);
    if (int'(count) < lo_mark) lo_mark = int'(count);
    pending_results.push_back('{prev: prior, occ: count, status: st});
  endfunction

  task check_result(logic [39:0] beat);
    result_t got, want;
    got = beat[35:0];
    n_results++;
    if (pending_results.size() == 0) begin
      report($sformatf("result beat %h with nothing outstanding", beat));
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status)
      report($sformatf("status %0d, expected %0d", got.status, want.status));
    if (got.occ !== want.occ)
      report($sformatf("occupancy %0d, expected %0d", got.occ, want.occ));
    if (got.prev !== want.prev)
      report($sformatf("previous occupancy %0d, expected %0d", got.prev, want.prev));
  endtask
endclass

module two_beam_direction_counter_core_tb;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // echo_a_us, echo_a_ok, echo_b_us, echo_b_ok, zero pad
  logic [39:0] in_tdata;
  // op
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // status, occupancy, previous_occupancy, zero pad
  logic [39:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  occupancy_checker sb;
  bit               allow_idle = 1'b1;
  int               n_settings = 0;

  two_beam_direction_counter_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver backpressure in short bursts
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (allow_idle && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #(64'd50_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_beat(bit op, logic [15:0] ea, bit oka, logic [15:0] eb, bit okb);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, okb, eb, oka, ea};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(op, ea, oka, eb, okb);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // back-to-back transfers keep psel high; caller releases the bus
  task automatic cfg_access(bit wr, cfg_reg_t idx, logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= 4'(idx * 4);
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
  endtask

  task automatic check_reg(cfg_reg_t idx);
    logic [31:0] rd;
    cfg_access(1'b0, idx, 32'd0, rd);
    if (rd !== sb.reg_value(idx))
      sb.report($sformatf("register %0d reads %h, expected %h", idx, rd, sb.reg_value(idx)));
  endtask

  task automatic apply_setting(int fac, int wlim, int hold);
    logic [31:0] rd;
    drain();
    cfg_access(1'b1, REG_FACTOR, fac, rd);
    sb.set_reg(REG_FACTOR, fac);
    cfg_access(1'b1, REG_WAIT_LIMIT, wlim, rd);
    sb.set_reg(REG_WAIT_LIMIT, wlim);
    cfg_access(1'b1, REG_HOLDOFF, hold, rd);
    sb.set_reg(REG_HOLDOFF, hold);
    check_reg(REG_FACTOR);
    check_reg(REG_WAIT_LIMIT);
    check_reg(REG_HOLDOFF);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    n_settings++;
  endtask

  // echo on the requested side of the presence threshold, often right at it
  function automatic logic [15:0] pick_echo(longint unsigned lim, bit blocked);
    longint unsigned cut;
    cut = (lim + 2559) / 2560;
    if (blocked) begin
      if (cut == 0) return 16'($urandom);
      if (cut > 65536) cut = 65536;
      if ($urandom_range(0, 3) == 0) return 16'(cut - 1);
      return 16'($urandom_range(0, 32'(cut - 1)));
    end
    if (cut > 65535) return 16'($urandom);
    if ($urandom_range(0, 3) == 0) return 16'(cut);
    return 16'($urandom_range(32'(cut), 65535));
  endfunction

  function automatic logic [15:0] near(int base);
    int lo, hi;
    lo = base - base / 8;
    hi = base + base / 8;
    if (hi > 65535) hi = 65535;
    return 16'($urandom_range(lo, hi));
  endfunction

  task automatic calibrate(int base_a, int base_b, bit spoil);
    int bad_at, r;
    bad_at = spoil ? $urandom_range(0, CAL_LEN - 1) : CAL_LEN;
    send_beat(1'b1, 16'($urandom), 1'($urandom_range(0, 1)), 16'($urandom),
              1'($urandom_range(0, 1)));
    for (int i = 0; i < CAL_LEN; i++) begin
      if (i == bad_at) begin
        r = $urandom_range(1, 3);
        send_beat(1'b0, 16'($urandom), !r[0], 16'($urandom), !r[1]);
        return;
      end
      send_beat(1'b0, near(base_a), 1'b1, near(base_b), 1'b1);
    end
  endtask

  task automatic run_crossing(bit a_first);
    int extra;
    bit ok;
    extra = $urandom_range(0, 3);
    if (sb.wait_lim <= 40 && $urandom_range(0, 7) == 0) extra = sb.wait_lim + 1;
    if (a_first)
      send_beat(1'b0, pick_echo(sb.lim_a, 1), 1'b1, pick_echo(sb.lim_b, 0), 1'b1);
    else
      send_beat(1'b0, pick_echo(sb.lim_a, 0), 1'b1, pick_echo(sb.lim_b, 1), 1'b1);
    // unconfirmed samples: the other sensor's fields do not matter
    repeat (extra) begin
      if (a_first)
        send_beat(1'b0, 16'($urandom), 1'($urandom_range(0, 1)), pick_echo(sb.lim_b, 0), 1'b1);
      else
        send_beat(1'b0, pick_echo(sb.lim_a, 0), 1'b1, 16'($urandom), 1'($urandom_range(0, 1)));
    end
    ok = $urandom_range(0, 9) != 0;
    if (a_first)
      send_beat(1'b0, 16'($urandom), 1'($urandom_range(0, 1)), pick_echo(sb.lim_b, 1), ok);
    else
      send_beat(1'b0, pick_echo(sb.lim_a, 1), ok, 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_traffic(int n_items);
    int start;
    start = sb.n_live;
    while (sb.n_live - start < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2: run_crossing(1'b1);
        3, 4, 5: run_crossing(1'b0);
        6: send_beat(1'b0, pick_echo(sb.lim_a, 1), 1'b1, pick_echo(sb.lim_b, 1), 1'b1);
        7, 8: send_beat($urandom_range(0, 15) == 0, 16'($urandom), 1'($urandom_range(0, 1)),
                        16'($urandom), 1'($urandom_range(0, 1)));
        default: begin
          if ($urandom_range(0, 3) == 0)
            calibrate($urandom_range(300, 30000), $urandom_range(300, 30000),
                      $urandom_range(0, 3) == 0);
          else
            send_beat(1'b0, 16'($urandom), 1'($urandom_range(0, 1)), 16'($urandom), 1'b0);
        end
      endcase
    end
  endtask

  int fac_tab[7]  = '{0, 256, 511, 204, 1, 128, 300};
  int wlim_tab[7] = '{1, 0, 1023, 3, 1, 25, 7};
  int hold_tab[7] = '{0, 1, 3, 0, 20, 2, 0};
  int len_tab[7]  = '{100, 120, 120, 150, 40, 120, 120};

  initial begin
    sb = new();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values of the registers
    check_reg(REG_FACTOR);
    check_reg(REG_WAIT_LIMIT);
    check_reg(REG_HOLDOFF);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;

    // before any calibration the limits never trigger
    send_beat(1'b0, 16'h0000, 1'b1, 16'h0000, 1'b1);
    send_beat(1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1);
    send_beat(1'b0, 16'hffff, 1'b1, 16'hffff, 1'b0);
    // start ignores its echoes; an invalid pair aborts calibration
    send_beat(1'b1, 16'hffff, 1'b0, 16'hffff, 1'b0);
    send_beat(1'b0, 16'h1234, 1'b1, 16'h1234, 1'b0);
    send_beat(1'b1, 16'h0000, 1'b1, 16'h0000, 1'b1);
    repeat (CAL_LEN) send_beat(1'b0, 16'hffff, 1'b1, 16'hffff, 1'b1);
    send_beat(1'b0, 16'hffff, 1'b1, 16'hffff, 1'b1);
    // both blocked: A has priority, only B is looked at next
    send_beat(1'b0, 16'h0000, 1'b1, 16'h0000, 1'b1);
    send_beat(1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1);
    send_beat(1'b0, 16'hffff, 1'b1, 16'h0000, 1'b1);
    send_beat(1'b0, 16'hffff, 1'b1, 16'h0000, 1'b1);
    send_beat(1'b0, 16'h0000, 1'b1, 16'hffff, 1'b0);
    // awaited sensor invalid while waiting
    send_beat(1'b0, 16'h0000, 1'b1, 16'hffff, 1'b1);
    send_beat(1'b0, 16'h0000, 1'b1, 16'hffff, 1'b0);
    // right at the threshold
    send_beat(1'b0, pick_echo(sb.lim_a, 1), 1'b1, 16'(((sb.lim_b + 2559) / 2560)), 1'b1);
    send_beat(1'b0, 16'h0000, 1'b1, 16'(((sb.lim_b + 2559) / 2560)), 1'b1);
    send_beat(1'b0, 16'h0000, 1'b1, 16'(((sb.lim_b + 2559) / 2560) - 1), 1'b1);

    for (int p = 0; p < 7; p++) begin
      apply_setting(fac_tab[p], wlim_tab[p], hold_tab[p]);
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 5) == 0) calibrate($urandom_range(300, 30000),
                                                 $urandom_range(300, 30000), 1'b1);
        calibrate($urandom_range(300, 65535), $urandom_range(300, 30000), 1'b0);
      end
      random_traffic(len_tab[p]);
    end

    // last part: full rate crossings in both directions
    drain();
    allow_idle = 1'b0;
    apply_setting(204, 25, 0);
    calibrate(40000, 40000, 1'b0);
    repeat (30) begin
      send_beat(1'b0, 16'hffff, 1'b1, 16'h0000, 1'b1);
      send_beat(1'b0, 16'h0000, 1'b1, 16'hffff, 1'b1);
    end
    repeat (30) begin
      send_beat(1'b0, 16'h0000, 1'b1, 16'hffff, 1'b1);
      send_beat(1'b0, 16'hffff, 1'b1, 16'h0000, 1'b1);
    end
    random_traffic(100);

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d beats (%0d outside holdoff), %0d results, %0d register settings",
             sb.n_samples, sb.n_live, sb.n_results, n_settings);
    $display("count ranged from %0d to %0d", sb.lo_mark, sb.hi_mark);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
